// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lpht_pkg.sv =====
// shared constants and controller/datapath interface types of the hash table
package lpht_pkg;

   localparam int unsigned TABLE_SIZE_DEFAULT = 16;
   localparam int unsigned KEY_BITS_DEFAULT   = 31;
   localparam int unsigned KEY_PORT_BITS      = 31;
   localparam int unsigned SLOT_BITS          = 4;
   localparam int unsigned HASH_DIGIT_BITS    = 4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic hash_step;
      logic probe_start;
      logic probe_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hash_last;
      logic probe_done;
   } sts_type;

endpackage

// ===== rtl/lpht_datapath.sv =====
// hash table datapath: key modulo unit, slot memory, probe pointers and result registers
module lpht_datapath #(
   parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT,
   parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lpht_pkg::cmd_type                cmd,
   output lpht_pkg::sts_type                sts,
   input  logic                             req_func,
   input  logic [lpht_pkg::KEY_PORT_BITS-1:0] req_key,
   input  logic                             req_end_of_batch,
   output logic                             rsp_found,
   output logic                             rsp_table_full,
   output logic [lpht_pkg::SLOT_BITS-1:0]   rsp_slot,
   output logic                             rsp_batch_done
);
   import lpht_pkg::*;

   localparam int unsigned AW         = $clog2(TABLE_SIZE);
   localparam int unsigned WIDE_BITS  = (KEY_BITS > KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int unsigned HASH_STEPS = (KEY_BITS + HASH_DIGIT_BITS - 1) / HASH_DIGIT_BITS;
   localparam int unsigned PAD_BITS   = HASH_STEPS * HASH_DIGIT_BITS;
   localparam int unsigned HCW        = $clog2(HASH_STEPS + 1);
   localparam int unsigned SW         = (AW > SLOT_BITS) ? AW : SLOT_BITS;
   localparam logic [AW-1:0]  LAST_SLOT = AW'(TABLE_SIZE - 1);
   localparam logic [AW:0]    MODULUS   = (AW + 1)'(TABLE_SIZE);
   localparam logic [HCW-1:0] LAST_HASH = HCW'(HASH_STEPS - 1);

   logic [KEY_BITS:0] mem [TABLE_SIZE];

   logic [WIDE_BITS-1:0] key_wide;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 func_ff, func_in;
   logic                 eob_ff, eob_in;
   logic [PAD_BITS-1:0]  digits_ff, digits_in;
   logic [AW-1:0]        rem_ff, rem_in;
   logic [HCW-1:0]       hcnt_ff, hcnt_in;
   logic [AW-1:0]        issue_ff, issue_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic [AW-1:0]        nchk_ff, nchk_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 found_ff, found_in;
   logic                 full_ff, full_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 bd_ff, bd_in;
   logic [KEY_BITS:0]    rd_word_ff;

   logic [AW:0]          acc;
   logic [AW-1:0]        rem_next_slot;
   logic [AW-1:0]        issue_next_slot;
   logic [AW-1:0]        rd_addr;
   logic                 mem_re;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [KEY_BITS:0]    mem_wdata;
   logic                 slot_empty;
   logic                 slot_match;
   logic                 store;
   logic [SW-1:0]        chk_wide;

   assign key_wide = WIDE_BITS'(req_key);

   // one digit of the key per step, remainder kept below the table size
   always_comb begin
      acc = {1'b0, rem_ff};
      for (int i = 0; i < HASH_DIGIT_BITS; i++) begin
         acc = {acc[AW-1:0], digits_ff[PAD_BITS-1-i]};
         if (acc >= MODULUS) begin
            acc = acc - MODULUS;
         end
      end
   end

   assign rem_next_slot   = (rem_ff == LAST_SLOT) ? '0 : rem_ff + 1'b1;
   assign issue_next_slot = (issue_ff == LAST_SLOT) ? '0 : issue_ff + 1'b1;

   assign slot_empty = !rd_word_ff[KEY_BITS];
   assign slot_match = rd_word_ff[KEY_BITS] && (rd_word_ff[KEY_BITS-1:0] == key_ff);
   assign store      = (func_ff == FUNC_INSERT) && slot_empty;
   assign chk_wide   = SW'(chk_ff);

   assign sts.clear_last = (clr_ff == LAST_SLOT);
   assign sts.hash_last  = (hcnt_ff == LAST_HASH);
   assign sts.probe_done = slot_empty || ((func_ff == FUNC_SEARCH) && slot_match)
                           || (nchk_ff == LAST_SLOT);

   assign rd_addr   = cmd.probe_start ? rem_ff : issue_ff;
   assign mem_re    = cmd.probe_start || cmd.probe_step;
   assign mem_we    = cmd.clear_step || (cmd.finish && store);
   assign mem_waddr = cmd.clear_step ? clr_ff : chk_ff;
   assign mem_wdata = cmd.clear_step ? '0 : {1'b1, key_ff};

   always_comb begin
      key_in    = key_ff;
      func_in   = func_ff;
      eob_in    = eob_ff;
      digits_in = digits_ff;
      rem_in    = rem_ff;
      hcnt_in   = hcnt_ff;
      issue_in  = issue_ff;
      chk_in    = chk_ff;
      nchk_in   = nchk_ff;
      clr_in    = clr_ff;
      found_in  = found_ff;
      full_in   = full_ff;
      slot_in   = slot_ff;
      bd_in     = bd_ff;
      if (cmd.clear_step) begin
         clr_in = (clr_ff == LAST_SLOT) ? '0 : clr_ff + 1'b1;
      end
      if (cmd.load) begin
         key_in    = key_wide[KEY_BITS-1:0];
         func_in   = req_func;
         eob_in    = req_end_of_batch;
         digits_in = PAD_BITS'(key_wide[KEY_BITS-1:0]);
         rem_in    = '0;
         hcnt_in   = '0;
      end
      if (cmd.hash_step) begin
         rem_in    = acc[AW-1:0];
         digits_in = digits_ff << HASH_DIGIT_BITS;
         hcnt_in   = hcnt_ff + 1'b1;
      end
      if (cmd.probe_start) begin
         chk_in   = rem_ff;
         issue_in = rem_next_slot;
         nchk_in  = '0;
      end
      if (cmd.probe_step) begin
         chk_in   = issue_ff;
         issue_in = issue_next_slot;
         nchk_in  = nchk_ff + 1'b1;
      end
      if (cmd.finish) begin
         found_in = (func_ff == FUNC_SEARCH) && slot_match;
         full_in  = (func_ff == FUNC_INSERT) && !slot_empty;
         slot_in  = (store || ((func_ff == FUNC_SEARCH) && slot_match))
                    ? chk_wide[SLOT_BITS-1:0] : '0;
         bd_in    = eob_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      key_ff    <= key_in;
      func_ff   <= func_in;
      eob_ff    <= eob_in;
      digits_ff <= digits_in;
      rem_ff    <= rem_in;
      hcnt_ff   <= hcnt_in;
      issue_ff  <= issue_in;
      chk_ff    <= chk_in;
      nchk_ff   <= nchk_in;
      found_ff  <= found_in;
      full_ff   <= full_in;
      slot_ff   <= slot_in;
      bd_ff     <= bd_in;
   end

   // slot memory: valid bit on top of the stored key
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rsp_found      = found_ff;
   assign rsp_table_full = full_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_batch_done = bd_ff;

endmodule

// ===== rtl/lpht_controller.sv =====
// hash table controller: clearing pass, hashing, probing and result handshake
module lpht_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lpht_pkg::cmd_type cmd,
   input  lpht_pkg::sts_type sts
);
   import lpht_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_LOOKUP,
      ST_PROBE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.probe_start = 1'b1;
            state_in        = ST_PROBE;
         end
         ST_PROBE: begin
            if (sts.probe_done) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.finish   = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/linear_probing_hash_table.sv =====
// top level of the linear probing hash table
//
// req channel: one item per operation, req_func selects insert or search of req_key.
// rsp channel: exactly one result item per request item, in order.
// the home slot is the key modulo TABLE_SIZE, worked out four key bits per cycle;
// then the slot memory is probed one slot per cycle, P probes with 1 <= P <= TABLE_SIZE.
// one item is worked on at a time; req_ready comes back together with rsp_valid,
// as the result is loaded. the result register lets a new item be accepted while
// the last result waits; if the receiver is still stalling when the next result is
// ready, probing holds on its final slot until rsp_ready frees the register.
// an insert into a full table stores nothing and flags rsp_table_full.
// after reset the table is cleared in a pass with req_ready low; rsp_valid is low
// from reset on.
module linear_probing_hash_table #(
   parameter int unsigned TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT,
   parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [lpht_pkg::KEY_PORT_BITS-1:0] req_key,
   input  logic                               req_end_of_batch,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic                               rsp_table_full,
   output logic [lpht_pkg::SLOT_BITS-1:0]     rsp_slot,
   output logic                               rsp_batch_done
);
   import lpht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lpht_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lpht_datapath #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_end_of_batch (req_end_of_batch),
      .rsp_found        (rsp_found),
      .rsp_table_full   (rsp_table_full),
      .rsp_slot         (rsp_slot),
      .rsp_batch_done   (rsp_batch_done)
   );

endmodule

// ===== rtl/lpht_checker.sv =====
// port-level checker for the hash table and its bind
`include "assert_macros.svh"

module lpht_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_found,
   input logic                           rsp_table_full,
   input logic [lpht_pkg::SLOT_BITS-1:0] rsp_slot,
   input logic                           rsp_batch_done
);

   `ASSERT_CLK(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped while stalled")

   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable({rsp_found, rsp_table_full, rsp_slot, rsp_batch_done}), "result item changed while stalled")

   `ASSERT_CLK(a_full_result, clock, reset, rsp_valid && rsp_table_full |-> !rsp_found && (rsp_slot == '0), "full table result carries a hit or a slot")

   `ASSERT_CLK(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "second item taken while one is in work")

   `ASSERT_CLK(a_clear_after_reset, clock, reset, $past(reset) |-> !req_ready && !rsp_valid, "channels active during clearing pass")

endmodule

bind linear_probing_hash_table lpht_checker u_lpht_checker (.*);
